// ===== hdl/pao_pkg.sv =====
`timescale 1ns / 1ps
// pao_pkg: word types, register indexes and constants of the pointer activity odometer
// no dependencies; imported by every module in hdl

package pao_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_BITS  = 17;
  localparam int QUOT_W    = 7;
  localparam int MS_REM_W  = 10;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               wheel_moved;
    logic [31:0]        time_ms;
    logic               press;
    logic               key_repeat;
  } event_t;

  typedef struct packed {
    logic [47:0] move_distance_total;
    logic [47:0] click_distance_total;
    logic [31:0] click_count;
    logic [31:0] key_count;
    logic [31:0] moving_seconds;
    logic        counted;
  } totals_t;

  typedef struct packed {
    logic [QUOT_W-1:0]   quot;
    logic [MS_REM_W-1:0] rem;
  } msdiv_res_t;

  localparam logic [1:0] KIND_MOVE   = 2'd0;
  localparam logic [1:0] KIND_BUTTON = 2'd1;
  localparam logic [1:0] KIND_KEY    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_WINDOW = 2'd2;

  localparam logic [7:0]  SENS_RESET     = 8'd3;
  localparam logic [15:0] MAXJUMP_RESET  = 16'd10000;
  localparam logic [15:0] WINDOW_RESET   = 16'd1000;

  localparam logic [MS_REM_W-1:0] MS_PER_S = 10'd1000;
  localparam logic [47:0] TOTAL_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

endpackage

// ===== hdl/pao_msdiv.sv =====
`timescale 1ns / 1ps
// pao_msdiv: bit-serial division of a millisecond sum by one thousand
// depends on pao_pkg

module pao_msdiv (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pao_pkg::DIV_BITS-1:0]  dividend,
  output logic                          busy,
  output pao_pkg::msdiv_res_t           res
);
  import pao_pkg::*;

  localparam int CNT_W = $clog2(DIV_BITS);

  logic [CNT_W-1:0]    cnt;
  logic [DIV_BITS-1:0] num;
  logic [DIV_BITS-1:0] quo;
  logic [MS_REM_W-1:0] r;
  logic [MS_REM_W:0]   r_sh;
  logic                ge;
  logic [MS_REM_W-1:0] r_next;

  always_comb begin
    r_sh   = {r, num[DIV_BITS-1]};
    ge     = r_sh >= {1'b0, MS_PER_S};
    r_next = ge ? MS_REM_W'(r_sh - {1'b0, MS_PER_S}) : r_sh[MS_REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(DIV_BITS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      quo <= '0;
      r   <= '0;
    end else if (busy) begin
      num <= {num[DIV_BITS-2:0], 1'b0};
      quo <= {quo[DIV_BITS-2:0], ge};
      r   <= r_next;
    end
  end

  assign res.quot = quo[QUOT_W-1:0];
  assign res.rem  = r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    busy |-> r < MS_PER_S)
    else $error("millisecond remainder reached the divisor");

endmodule

// ===== hdl/pao_sqdist.sv =====
`timescale 1ns / 1ps
// pao_sqdist: floored euclidean distance, serial sum of squares then a bit-pair square root
// depends on pao_pkg

module pao_sqdist #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] dx,
  input  logic [COORD_BITS-1:0] dy,
  output logic                  busy,
  output logic [COORD_BITS:0]   root
);
  import pao_pkg::*;

  localparam int N     = COORD_BITS + 1;
  localparam int W     = 2 * N;
  localparam int CNT_W = $clog2(N);

  typedef enum logic [1:0] {SQ_IDLE, SQ_MUL, SQ_ROOT} sq_state_t;

  sq_state_t             state;
  logic [CNT_W-1:0]      cnt;
  logic [COORD_BITS-1:0] ax;
  logic [COORD_BITS-1:0] ay;
  logic [COORD_BITS-1:0] bx;
  logic [COORD_BITS-1:0] by;
  logic [W-1:0]          acc;
  logic [N:0]            rem;
  logic [W-1:0]          addend;
  logic [W-1:0]          acc_mul;
  logic [N+2:0]          rem_sh;
  logic [N+2:0]          trial;
  logic                  fits;
  logic [N:0]            rem_next;

  always_comb begin
    addend   = W'(ax & {COORD_BITS{bx[COORD_BITS-1]}})
             + W'(ay & {COORD_BITS{by[COORD_BITS-1]}});
    acc_mul  = {acc[W-2:0], 1'b0} + addend;
    rem_sh   = {rem, acc[W-1:W-2]};
    trial    = {1'b0, root, 2'b01};
    fits     = rem_sh >= trial;
    rem_next = fits ? (N+1)'(rem_sh - trial) : rem_sh[N:0];
  end

  assign busy = (state != SQ_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        SQ_IDLE: begin
          if (start) begin
            state <= SQ_MUL;
            cnt   <= '0;
            ax    <= dx;
            ay    <= dy;
            bx    <= dx;
            by    <= dy;
            acc   <= '0;
          end
        end
        SQ_MUL: begin
          acc <= acc_mul;
          bx  <= {bx[COORD_BITS-2:0], 1'b0};
          by  <= {by[COORD_BITS-2:0], 1'b0};
          if (cnt == CNT_W'(COORD_BITS - 1)) begin
            state <= SQ_ROOT;
            cnt   <= '0;
            rem   <= '0;
            root  <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        SQ_ROOT: begin
          acc  <= {acc[W-3:0], 2'b00};
          rem  <= rem_next;
          root <= {root[N-2:0], fits};
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(N - 1)) begin
            state <= SQ_IDLE;
          end
        end
        default: begin
          state <= SQ_IDLE;
        end
      endcase
    end
  end

  a_rem_bounded: assert property (@(posedge clk) disable iff (rst)
    state == SQ_ROOT |-> rem <= {root, 1'b0})
    else $error("square root remainder above twice the partial root");

endmodule

// ===== hdl/pointer_activity_odometer.sv =====
`timescale 1ns / 1ps
// pointer_activity_odometer: top level, event decode, position and total registers
// depends on pao_pkg, pao_sqdist, pao_msdiv
//
// usage
//   event channel (event_valid, event_stall, event_data) takes one pointer move,
//   button or key word at a time; it is stalled from acceptance until the result
//   word has been loaded into the output register
//   totals channel (totals_valid, totals_stall, totals_data) gives one word per
//   event: all running totals after the event and whether it counted
//   cfg_we, cfg_index, cfg_data write sensitivity, jump limit and time window
// timing
//   the time from acceptance to the totals word is set by the longer of the serial
//   sum of squares plus bit-pair square root in pao_sqdist and the division in
//   pao_msdiv; the next event is taken in the cycle after the word is loaded
//   the next event is taken while the previous result still waits in the output
//   register; a stalled totals word holds, and a finished event waits in its
//   final step until the output register is free
// reset
//   synchronous rst clears positions, totals and the output valid, and loads the
//   register defaults 3, 10000 and 1000

module pointer_activity_odometer #(
  parameter int COORD_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            event_valid,
  output logic                            event_stall,
  input  pao_pkg::event_t                 event_data,
  output logic                            totals_valid,
  input  logic                            totals_stall,
  output pao_pkg::totals_t                totals_data,
  input  logic                            cfg_we,
  input  logic [pao_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pao_pkg::CFG_W-1:0]       cfg_data
);
  import pao_pkg::*;

  localparam int N    = COORD_BITS + 1;
  localparam int CMPW = (COORD_BITS > 16) ? COORD_BITS : 16;

  typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_WAIT, ST_COMMIT} state_t;

  state_t                state;
  event_t                ev;
  logic [7:0]            sensitivity;
  logic [15:0]           jump_limit;
  logic [15:0]           time_window;
  logic [COORD_BITS-1:0] last_x;
  logic [COORD_BITS-1:0] last_y;
  logic [COORD_BITS-1:0] click_x;
  logic [COORD_BITS-1:0] click_y;
  logic                  last_valid;
  logic                  click_valid;
  logic                  time_valid;
  logic [31:0]           last_move_time;
  logic [47:0]           move_total;
  logic [47:0]           click_move_total;
  logic [31:0]           clicks;
  logic [31:0]           keys;
  logic [31:0]           secs;
  logic [MS_REM_W-1:0]   rem_ms;
  logic                  f_move;
  logic                  f_click;
  logic                  f_press;
  logic                  f_key;
  logic                  f_gap;

  logic [COORD_BITS-1:0] cx;
  logic [COORD_BITS-1:0] cy;
  logic [COORD_BITS-1:0] sens_c;
  logic [COORD_BITS-1:0] mv_dx;
  logic [COORD_BITS-1:0] mv_dy;
  logic [COORD_BITS-1:0] ck_dx;
  logic [COORD_BITS-1:0] ck_dy;
  logic                  coords_ok;
  logic                  mv_pass;
  logic [31:0]           gap;
  logic                  gap_ok;
  logic                  start;
  logic [COORD_BITS-1:0] op_dx;
  logic [COORD_BITS-1:0] op_dy;
  logic [DIV_BITS-1:0]   div_in;
  logic                  sq_busy;
  logic                  div_busy;
  logic [N-1:0]          sq_root;
  msdiv_res_t            div_res;

  logic [48:0]           mv_sum;
  logic [48:0]           ck_sum;
  logic [32:0]           secs_sum;
  logic [47:0]           move_next;
  logic [47:0]           click_next;
  logic [31:0]           clicks_next;
  logic [31:0]           keys_next;
  logic [31:0]           secs_next;

  function automatic logic [COORD_BITS-1:0] absdiff(input logic [COORD_BITS-1:0] a,
                                                    input logic [COORD_BITS-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // event decode
  always_comb begin
    cx        = COORD_BITS'(ev.pos_x);
    cy        = COORD_BITS'(ev.pos_y);
    coords_ok = !cx[COORD_BITS-1] && !cy[COORD_BITS-1];
    sens_c    = COORD_BITS'(sensitivity);
    mv_dx     = last_valid ? absdiff(cx, last_x) : sens_c;
    mv_dy     = last_valid ? absdiff(cy, last_y) : sens_c;
    mv_pass   = (CMPW'(mv_dx) < CMPW'(jump_limit)) && (CMPW'(mv_dy) < CMPW'(jump_limit))
              && (mv_dx >= sens_c || mv_dy >= sens_c || ev.wheel_moved);
    ck_dx     = absdiff(click_x, last_x);
    ck_dy     = absdiff(click_y, last_y);
    gap       = ev.time_ms - last_move_time;
    gap_ok    = time_valid && (gap < 32'(time_window));
    div_in    = DIV_BITS'(rem_ms) + DIV_BITS'(gap[15:0]);
    start     = (state == ST_PREP);
    op_dx     = (ev.kind == KIND_BUTTON) ? ck_dx : mv_dx;
    op_dy     = (ev.kind == KIND_BUTTON) ? ck_dy : mv_dy;
  end

  // saturating totals
  always_comb begin
    mv_sum      = {1'b0, move_total} + 49'(sq_root);
    ck_sum      = {1'b0, click_move_total} + 49'(sq_root);
    secs_sum    = {1'b0, secs} + 33'(div_res.quot);
    move_next   = move_total;
    click_next  = click_move_total;
    clicks_next = clicks;
    keys_next   = keys;
    secs_next   = secs;
    if (f_move) begin
      move_next = (mv_sum >= {1'b0, TOTAL_MAX}) ? TOTAL_MAX : mv_sum[47:0];
    end
    if (f_click) begin
      click_next = (ck_sum >= {1'b0, TOTAL_MAX}) ? TOTAL_MAX : ck_sum[47:0];
    end
    if (f_press && clicks != COUNT_MAX) begin
      clicks_next = clicks + 1'b1;
    end
    if (f_key && keys != COUNT_MAX) begin
      keys_next = keys + 1'b1;
    end
    if (f_gap) begin
      secs_next = secs_sum[32] ? COUNT_MAX : secs_sum[31:0];
    end
  end

  assign event_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (event_valid && !event_stall) begin
      ev <= event_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      totals_valid     <= 1'b0;
      sensitivity      <= SENS_RESET;
      jump_limit       <= MAXJUMP_RESET;
      time_window      <= WINDOW_RESET;
      last_x           <= '0;
      last_y           <= '0;
      click_x          <= '0;
      click_y          <= '0;
      last_valid       <= 1'b0;
      click_valid      <= 1'b0;
      time_valid       <= 1'b0;
      last_move_time   <= '0;
      move_total       <= '0;
      click_move_total <= '0;
      clicks           <= '0;
      keys             <= '0;
      secs             <= '0;
      rem_ms           <= '0;
      f_move           <= 1'b0;
      f_click          <= 1'b0;
      f_press          <= 1'b0;
      f_key            <= 1'b0;
      f_gap            <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SENSITIVITY: sensitivity <= cfg_data[7:0];
          REG_JUMP_LIMIT:  jump_limit  <= cfg_data;
          REG_TIME_WINDOW: time_window <= cfg_data;
          default: ;
        endcase
      end
      if (totals_valid && !totals_stall && state != ST_COMMIT) begin
        totals_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (event_valid) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          f_move  <= (ev.kind == KIND_MOVE) && coords_ok && mv_pass;
          f_gap   <= (ev.kind == KIND_MOVE) && coords_ok && mv_pass && gap_ok;
          f_click <= (ev.kind == KIND_BUTTON) && click_valid && last_valid;
          f_press <= (ev.kind == KIND_BUTTON) && ev.press;
          f_key   <= (ev.kind == KIND_KEY) && !ev.key_repeat;
          case (ev.kind)
            KIND_MOVE: begin
              if (coords_ok) begin
                last_x     <= cx;
                last_y     <= cy;
                last_valid <= 1'b1;
                if (mv_pass) begin
                  last_move_time <= ev.time_ms;
                  time_valid     <= 1'b1;
                end
              end
            end
            KIND_BUTTON: begin
              click_x     <= last_x;
              click_y     <= last_y;
              click_valid <= last_valid;
            end
            default: ;
          endcase
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (!sq_busy && !div_busy) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (!totals_valid || !totals_stall) begin
            move_total                       <= move_next;
            click_move_total                 <= click_next;
            clicks                           <= clicks_next;
            keys                             <= keys_next;
            secs                             <= secs_next;
            if (f_gap) begin
              rem_ms <= div_res.rem;
            end
            totals_data.move_distance_total  <= move_next;
            totals_data.click_distance_total <= click_next;
            totals_data.click_count          <= clicks_next;
            totals_data.key_count            <= keys_next;
            totals_data.moving_seconds       <= secs_next;
            totals_data.counted              <= f_move | f_click | f_press | f_key;
            totals_valid                     <= 1'b1;
            state                            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  pao_sqdist #(
    .COORD_BITS (COORD_BITS)
  ) u_sqdist (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .dx    (op_dx),
    .dy    (op_dy),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  pao_msdiv u_msdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (div_in),
    .busy     (div_busy),
    .res      (div_res)
  );

  a_units_idle_on_accept: assert property (@(posedge clk) disable iff (rst)
    event_valid && !event_stall |-> !sq_busy && !div_busy)
    else $error("word accepted while an arithmetic unit is still busy");

  a_commit_after_units: assert property (@(posedge clk) disable iff (rst)
    state == ST_COMMIT |-> !sq_busy && !div_busy)
    else $error("totals committed before the arithmetic units finished");

  a_counts_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> clicks >= $past(clicks) && keys >= $past(keys) && secs >= $past(secs))
    else $error("a running count went down");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for pointer_activity_odometer, with its own running-total
// predictor, directed edge cases, register extremes and random traffic under idling
// depends on pao_pkg and pointer_activity_odometer from hdl

module tb;
  import pao_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic event_valid = 1'b0;
  logic event_stall;
  event_t event_data = '0;
  logic totals_valid;
  logic totals_stall = 1'b0;
  totals_t totals_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  pointer_activity_odometer DUT (
    .clk(clk),
    .rst(rst),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .event_data(event_data),
    .totals_valid(totals_valid),
    .totals_stall(totals_stall),
    .totals_data(totals_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of registers and state
  logic [7:0]  cur_sens = SENS_RESET;
  logic [15:0] cur_jump = MAXJUMP_RESET;
  logic [15:0] cur_window = WINDOW_RESET;
  logic [15:0] ptr_x = '0, ptr_y = '0, anchor_x = '0, anchor_y = '0;
  logic        ptr_known = 1'b0, anchor_known = 1'b0, move_ms_known = 1'b0;
  logic [47:0] travel = '0, click_travel = '0, active_ms = '0;
  logic [31:0] presses = '0, strokes = '0, prev_move_ms = '0;

  totals_t expected_totals[$];
  totals_t want;
  int errors = 0;
  int events_sent = 0;
  int words_checked = 0;
  int settings_used = 1;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // stimulus walk
  int walk_x = 0, walk_y = 0;
  logic [31:0] walk_ms = '0;

  function automatic logic [31:0] floor_root(input logic [63:0] v);
    logic [31:0] root, trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if ({32'd0, trial} * {32'd0, trial} <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic [63:0] span(input logic [15:0] a, input logic [15:0] b);
    return (a >= b) ? 64'(a - b) : 64'(b - a);
  endfunction

  function automatic logic [47:0] sat_sum(input logic [47:0] a, input logic [47:0] b,
                                          input logic [47:0] top);
    return (b >= top - a) ? top : a + b;
  endfunction

  function automatic totals_t advance_odometer(input event_t ev);
    logic [15:0] x, y;
    logic [63:0] dx, dy;
    logic [31:0] gap;
    logic [47:0] secs;
    logic hit;
    totals_t res;
    x = ev.pos_x;
    y = ev.pos_y;
    hit = 1'b0;
    case (ev.kind)
      KIND_MOVE: if (!x[15] && !y[15]) begin
        dx = ptr_known ? span(x, ptr_x) : 64'(cur_sens);
        dy = ptr_known ? span(y, ptr_y) : 64'(cur_sens);
        ptr_x = x;
        ptr_y = y;
        ptr_known = 1'b1;
        if (dx < cur_jump && dy < cur_jump &&
            (dx >= cur_sens || dy >= cur_sens || ev.wheel_moved)) begin
          hit = 1'b1;
          travel = sat_sum(travel, 48'(floor_root(dx * dx + dy * dy)), TOTAL_MAX);
          if (move_ms_known) begin
            gap = ev.time_ms - prev_move_ms;
            if (gap < cur_window) active_ms = sat_sum(active_ms, 48'(gap), TOTAL_MAX);
          end
          prev_move_ms = ev.time_ms;
          move_ms_known = 1'b1;
        end
      end
      KIND_BUTTON: begin
        if (anchor_known && ptr_known) begin
          dx = span(anchor_x, ptr_x);
          dy = span(anchor_y, ptr_y);
          click_travel = sat_sum(click_travel, 48'(floor_root(dx * dx + dy * dy)), TOTAL_MAX);
          hit = 1'b1;
        end
        anchor_x = ptr_x;
        anchor_y = ptr_y;
        anchor_known = ptr_known;
        if (ev.press) begin
          presses = 32'(sat_sum(48'(presses), 48'd1, 48'(COUNT_MAX)));
          hit = 1'b1;
        end
      end
      KIND_KEY: if (!ev.key_repeat) begin
        strokes = 32'(sat_sum(48'(strokes), 48'd1, 48'(COUNT_MAX)));
        hit = 1'b1;
      end
      default: ;
    endcase
    secs = active_ms / 48'd1000;
    res.move_distance_total = travel;
    res.click_distance_total = click_travel;
    res.click_count = presses;
    res.key_count = strokes;
    res.moving_seconds = (secs > 48'(COUNT_MAX)) ? COUNT_MAX : secs[31:0];
    res.counted = hit;
    return res;
  endfunction

  function automatic event_t noise_item();
    event_t ev;
    ev.kind = 2'($urandom);
    ev.pos_x = 16'($urandom);
    ev.pos_y = 16'($urandom);
    ev.wheel_moved = 1'($urandom);
    ev.time_ms = $urandom;
    ev.press = 1'($urandom);
    ev.key_repeat = 1'($urandom);
    return ev;
  endfunction

  function automatic event_t mk_move(input int x, input int y, input logic wheel,
                                     input logic [31:0] ms);
    event_t ev;
    ev = noise_item();
    ev.kind = KIND_MOVE;
    ev.pos_x = 16'(x);
    ev.pos_y = 16'(y);
    ev.wheel_moved = wheel;
    ev.time_ms = ms;
    return ev;
  endfunction

  function automatic event_t mk_button(input logic pressed);
    event_t ev;
    ev = noise_item();
    ev.kind = KIND_BUTTON;
    ev.press = pressed;
    return ev;
  endfunction

  function automatic event_t mk_key(input logic repeated);
    event_t ev;
    ev = noise_item();
    ev.kind = KIND_KEY;
    ev.key_repeat = repeated;
    return ev;
  endfunction

  function automatic event_t next_random_item();
    event_t ev;
    int r, lim;
    r = $urandom_range(99);
    if (r < 58) begin
      lim = ($urandom_range(3) == 0) ? int'(cur_jump) + 20 : 3 * int'(cur_sens) + 4;
      walk_x = walk_x + int'($urandom_range(2 * lim)) - lim;
      walk_y = walk_y + int'($urandom_range(2 * lim)) - lim;
      if (walk_x < 0) walk_x = 0;
      if (walk_x > 32767) walk_x = 32767;
      if (walk_y < 0) walk_y = 0;
      if (walk_y > 32767) walk_y = 32767;
      if ($urandom_range(31) == 0) walk_ms = $urandom;
      else if ($urandom_range(4) == 0) walk_ms = walk_ms + $urandom_range(70000);
      else walk_ms = walk_ms + $urandom_range(int'(cur_window) + 50);
      ev = mk_move(walk_x, walk_y, $urandom_range(7) == 0, walk_ms);
    end else if (r < 64) begin
      ev = noise_item();
      ev.kind = KIND_MOVE;
      if (!ev.pos_x[15] && !ev.pos_y[15]) begin
        walk_x = int'(ev.pos_x);
        walk_y = int'(ev.pos_y);
      end
    end else if (r < 76) begin
      ev = mk_button(1'($urandom));
    end else if (r < 92) begin
      ev = mk_key($urandom_range(3) == 0);
    end else if (r < 96) begin
      ev = noise_item();
      ev.kind = KIND_UNUSED;
    end else begin
      ev = noise_item();
    end
    return ev;
  endfunction

  task automatic send_event(input event_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      event_valid <= 1'b0;
      @(posedge clk);
    end
    event_valid <= 1'b1;
    event_data <= ev;
    @(posedge clk);
    while (event_stall) @(posedge clk);
    expected_totals.insert(expected_totals.size(), advance_odometer(ev));
    events_sent++;
  endtask

  task automatic drain();
    event_valid <= 1'b0;
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] sens, input logic [15:0] jump,
                            input logic [15:0] window);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_SENSITIVITY;
    cfg_data <= {8'd0, sens};
    @(posedge clk);
    cfg_index <= REG_JUMP_LIMIT;
    cfg_data <= jump;
    @(posedge clk);
    cfg_index <= REG_TIME_WINDOW;
    cfg_data <= window;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_sens = sens;
    cur_jump = jump;
    cur_window = window;
    settings_used++;
  endtask

  task automatic test_events_without_position();
    send_event(mk_button(1'b1));
    send_event(mk_button(1'b0));
    send_event(mk_key(1'b1));
    send_event(mk_key(1'b0));
    send_event(mk_move(5, 5, 1'b1, 32'd0) ^ {KIND_UNUSED, 67'd0});
  endtask

  task automatic test_invalid_coordinates();
    send_event(mk_move(-1, 100, 1'b1, 32'd5));
    send_event(mk_move(100, -32768, 1'b1, 32'd6));
  endtask

  task automatic test_move_rules();
    send_event(mk_move(32767, 0, 1'b0, 32'd100));
    send_event(mk_move(32766, 1, 1'b0, 32'd300));
    send_event(mk_move(32766, 1, 1'b1, 32'd500));
    send_event(mk_move(22766, 1, 1'b0, 32'd600));
    send_event(mk_move(12767, 1, 1'b0, 32'd700));
  endtask

  task automatic test_time_gaps();
    send_event(mk_move(12767, 4, 1'b0, 32'd1699));
    send_event(mk_move(12767, 7, 1'b0, 32'd2699));
    send_event(mk_move(12767, 10, 1'b0, 32'hFFFF_FF00));
    send_event(mk_move(12767, 13, 1'b0, 32'h0000_0010));
    send_event(mk_move(12767, 16, 1'b0, 32'h0000_0010));
  endtask

  task automatic test_click_travel();
    send_event(mk_button(1'b1));
    send_event(mk_move(0, 0, 1'b0, 32'h0000_0020));
    send_event(mk_button(1'b0));
    send_event(mk_button(1'b1));
  endtask

  task automatic test_register_extremes();
    set_config(8'd0, 16'd1, 16'd1);
    send_event(mk_move(0, 0, 1'b0, 32'h0000_0010));
    send_event(mk_move(1, 0, 1'b0, 32'h0000_0020));
    set_config(8'd255, 16'd65535, 16'd65535);
    send_event(mk_move(32767, 32767, 1'b0, 32'h0000_0010 + 32'd65534));
    send_event(mk_move(32513, 32767, 1'b0, 32'h0000_0010 + 32'd65535));
    send_event(mk_move(32513, 32767, 1'b1, 32'h0000_0010 + 32'd65534 + 32'd65535));
  endtask

  task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct,
                                     input logic use_defaults);
    event_t ev;
    int useful;
    if (use_defaults) set_config(SENS_RESET, MAXJUMP_RESET, WINDOW_RESET);
    else set_config(8'($urandom_range(12)), 16'($urandom_range(2000, 30)),
                    16'($urandom_range(3000, 100)));
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    useful = 0;
    while (useful < n) begin
      ev = next_random_item();
      send_event(ev);
      if (!(ev.kind == KIND_UNUSED || (ev.kind == KIND_KEY && ev.key_repeat) ||
            (ev.kind == KIND_MOVE && (ev.pos_x[15] || ev.pos_y[15])))) useful++;
      if (useful % 250 == 249) drain();
    end
  endtask

  task automatic report_field(input string name, input logic [47:0] exp_v,
                              input logic [47:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    totals_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && totals_valid && !totals_stall) begin
      if (expected_totals.size() == 0) begin
        $display("%0t ns: totals word with none expected: %h", $time, totals_data);
        errors++;
      end else begin
        want = expected_totals.pop_front();
        report_field("move_distance_total", want.move_distance_total,
                     totals_data.move_distance_total);
        report_field("click_distance_total", want.click_distance_total,
                     totals_data.click_distance_total);
        report_field("click_count", 48'(want.click_count), 48'(totals_data.click_count));
        report_field("key_count", 48'(want.key_count), 48'(totals_data.key_count));
        report_field("moving_seconds", 48'(want.moving_seconds),
                     48'(totals_data.moving_seconds));
        report_field("counted", 48'(want.counted), 48'(totals_data.counted));
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (event_valid && !event_stall) || (totals_valid && !totals_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 34;
    recv_stall_pct = 48;
    test_events_without_position();
    test_invalid_coordinates();
    test_move_rules();
    test_time_gaps();
    test_click_travel();
    test_register_extremes();
    test_random_traffic(580, 34, 48, 1'b0);
    test_random_traffic(580, 48, 34, 1'b0);
    test_random_traffic(580, 0, 0, 1'b1);
    drain();
    $display("%0d event words sent, %0d totals words checked", events_sent, words_checked);
    $display("covered edge cases, %0d register settings and three idling profiles",
             settings_used);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
